@@ rtl/core/bwrs_pkg.sv @@
// Shared types, constants and the microcode program of the burst/wait stats block.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package bwrs_pkg;

    localparam int SampleW  = 32;
    localparam int CountW   = 31;
    localparam int TotalW   = 64;
    localparam int DivSteps = TotalW;
    localparam int DivCntW  = $clog2(DivSteps);
    localparam int PcW      = 3;

    localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};

    typedef logic [PcW-1:0] pc_t;

    // datapath function of one step
    typedef enum logic [2:0] {
        FN_IDLE,
        FN_MUL,
        FN_ADD,
        FN_DIV,
        FN_FIX,
        FN_PUB
    } func_t;

    // jump condition of one step
    typedef enum logic [1:0] {
        CD_NEXT,
        CD_ALWAYS,
        CD_SKIP,
        CD_DIV_MORE
    } cond_t;

    typedef struct packed {
        func_t func;
        cond_t cond;
        pc_t   target;
    } ucode_t;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic skip;
        logic div_more;
    } dp_status_t;

    // program addresses
    localparam pc_t STEP_IDLE = 3'd0;
    localparam pc_t STEP_MUL  = 3'd1;
    localparam pc_t STEP_ADD  = 3'd2;
    localparam pc_t STEP_DIV  = 3'd3;
    localparam pc_t STEP_FIX  = 3'd4;
    localparam pc_t STEP_PUB  = 3'd5;

    // control store
    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t uw;
        unique case (pc)
            STEP_IDLE: uw = '{func: FN_IDLE, cond: CD_NEXT,     target: STEP_IDLE};
            STEP_MUL:  uw = '{func: FN_MUL,  cond: CD_SKIP,     target: STEP_PUB};
            STEP_ADD:  uw = '{func: FN_ADD,  cond: CD_NEXT,     target: STEP_IDLE};
            STEP_DIV:  uw = '{func: FN_DIV,  cond: CD_DIV_MORE, target: STEP_DIV};
            STEP_FIX:  uw = '{func: FN_FIX,  cond: CD_NEXT,     target: STEP_IDLE};
            STEP_PUB:  uw = '{func: FN_PUB,  cond: CD_ALWAYS,   target: STEP_IDLE};
            default:   uw = '{func: FN_IDLE, cond: CD_ALWAYS,   target: STEP_IDLE};
        endcase
        return uw;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/bwrs_seq.sv @@
// Microcode sequencer: step counter, control store read and jump logic.
// Depends on bwrs_pkg.
`default_nettype none

module bwrs_seq (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic                out_free,
    input  wire bwrs_pkg::dp_status_t status,
    output bwrs_pkg::ucode_t         ctrl
);

    bwrs_pkg::pc_t pc_reg;
    bwrs_pkg::pc_t pc_next;
    logic          hold;
    logic          take_jump;

    assign ctrl = bwrs_pkg::ucode_rom(pc_reg);

    // a step holds while it waits on a handshake
    assign hold = ((ctrl.func == bwrs_pkg::FN_IDLE) && !s_valid) ||
                  ((ctrl.func == bwrs_pkg::FN_PUB) && !out_free);

    // jump condition decode
    always_comb begin
        unique case (ctrl.cond)
            bwrs_pkg::CD_NEXT:     take_jump = 1'b0;
            bwrs_pkg::CD_ALWAYS:   take_jump = 1'b1;
            bwrs_pkg::CD_SKIP:     take_jump = status.skip;
            bwrs_pkg::CD_DIV_MORE: take_jump = status.div_more;
            default:               take_jump = 1'b0;
        endcase
    end

    always_comb begin
        if (hold) begin
            pc_next = pc_reg;
        end else if (take_jump) begin
            pc_next = ctrl.target;
        end else begin
            pc_next = pc_reg + bwrs_pkg::pc_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= bwrs_pkg::STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/bwrs_datapath.sv @@
// Datapath: statistics registers, multiplier, adder and bit-serial signed divider.
// Driven by the control word of bwrs_seq; depends on bwrs_pkg.
`default_nettype none

module bwrs_datapath (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire bwrs_pkg::ucode_t                      ctrl,
    input  wire logic                                  s_valid,
    input  wire logic                                  s_operation,
    input  wire logic signed [bwrs_pkg::SampleW-1:0]   s_sample,
    output bwrs_pkg::dp_status_t                       status,
    output logic signed [bwrs_pkg::SampleW-1:0]        burst_mean,
    output logic        [bwrs_pkg::CountW-1:0]         burst_smallest,
    output logic        [bwrs_pkg::CountW-1:0]         burst_largest,
    output logic        [bwrs_pkg::CountW-1:0]         burst_tally,
    output logic signed [bwrs_pkg::SampleW-1:0]        wait_mean,
    output logic        [bwrs_pkg::CountW-1:0]         wait_tally
);

    localparam int SW = bwrs_pkg::SampleW;
    localparam int CW = bwrs_pkg::CountW;
    localparam int TW = bwrs_pkg::TotalW;
    localparam int NW = bwrs_pkg::DivCntW;

    // captured word
    logic                 op_reg,      op_next;
    logic signed [SW-1:0] sample_reg,  sample_next;
    // arithmetic
    logic signed [TW-1:0] prod_reg,    prod_next;
    logic        [TW-1:0] dvd_reg,     dvd_next;
    logic        [SW-1:0] rem_reg,     rem_next;
    logic        [SW-1:0] divisor_reg, divisor_next;
    logic                 neg_reg,     neg_next;
    logic        [NW-1:0] cnt_reg,     cnt_next;
    // statistics
    logic signed [SW-1:0] bmean_reg,   bmean_next;
    logic        [CW-1:0] bmin_reg,    bmin_next;
    logic        [CW-1:0] bmax_reg,    bmax_next;
    logic        [CW-1:0] bcnt_reg,    bcnt_next;
    logic signed [SW-1:0] wmean_reg,   wmean_next;
    logic        [CW-1:0] wcnt_reg,    wcnt_next;

    logic signed [SW-1:0] sel_mean;
    logic        [CW-1:0] sel_count;
    logic signed [TW-1:0] total;
    logic        [SW:0]   rem_sh;
    logic                 q_bit;
    logic        [SW-1:0] q_mag;
    logic signed [SW-1:0] mean_new;
    logic        [CW-1:0] pos_sample;

    assign sel_mean   = op_reg ? wmean_reg : bmean_reg;
    assign sel_count  = op_reg ? wcnt_reg  : bcnt_reg;
    assign total      = prod_reg + TW'(sample_reg);
    assign rem_sh     = {rem_reg, dvd_reg[TW-1]};
    assign q_bit      = rem_sh >= {1'b0, divisor_reg};
    assign q_mag      = dvd_reg[SW-1:0];
    assign mean_new   = neg_reg ? -$signed(q_mag) : $signed(q_mag);
    assign pos_sample = sample_reg[CW-1:0];

    // flags for the sequencer
    assign status.skip     = op_reg ? (wcnt_reg == bwrs_pkg::COUNT_MAX)
                                    : ((sample_reg <= 0) || (bcnt_reg == bwrs_pkg::COUNT_MAX));
    assign status.div_more = cnt_reg != NW'(bwrs_pkg::DivSteps - 1);

    // step functions
    always_comb begin
        op_next      = op_reg;
        sample_next  = sample_reg;
        prod_next    = prod_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        neg_next     = neg_reg;
        cnt_next     = cnt_reg;
        bmean_next   = bmean_reg;
        bmin_next    = bmin_reg;
        bmax_next    = bmax_reg;
        bcnt_next    = bcnt_reg;
        wmean_next   = wmean_reg;
        wcnt_next    = wcnt_reg;
        case (ctrl.func)
            bwrs_pkg::FN_IDLE: begin
                if (s_valid) begin
                    op_next     = s_operation;
                    sample_next = s_sample;
                end
            end
            bwrs_pkg::FN_MUL: begin
                prod_next = TW'(sel_mean) * TW'($signed({1'b0, sel_count}));
            end
            bwrs_pkg::FN_ADD: begin
                neg_next     = total[TW-1];
                dvd_next     = total[TW-1] ? TW'(-total) : TW'(total);
                rem_next     = '0;
                divisor_next = {1'b0, sel_count} + SW'(1);
                cnt_next     = '0;
            end
            bwrs_pkg::FN_DIV: begin
                // one restoring step, quotient bits shift into the dividend
                rem_next = q_bit ? SW'(rem_sh - {1'b0, divisor_reg}) : rem_sh[SW-1:0];
                dvd_next = {dvd_reg[TW-2:0], q_bit};
                cnt_next = cnt_reg + NW'(1);
            end
            bwrs_pkg::FN_FIX: begin
                if (op_reg) begin
                    wmean_next = mean_new;
                    wcnt_next  = wcnt_reg + CW'(1);
                end else begin
                    bmean_next = mean_new;
                    bcnt_next  = bcnt_reg + CW'(1);
                    if (pos_sample < bmin_reg) begin
                        bmin_next = pos_sample;
                    end
                    if (pos_sample > bmax_reg) begin
                        bmax_next = pos_sample;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // working registers
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        sample_reg  <= sample_next;
        prod_reg    <= prod_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        neg_reg     <= neg_next;
        cnt_reg     <= cnt_next;
    end

    // statistics registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bmean_reg <= '0;
            bmin_reg  <= bwrs_pkg::COUNT_MAX;
            bmax_reg  <= '0;
            bcnt_reg  <= '0;
            wmean_reg <= '0;
            wcnt_reg  <= '0;
        end else begin
            bmean_reg <= bmean_next;
            bmin_reg  <= bmin_next;
            bmax_reg  <= bmax_next;
            bcnt_reg  <= bcnt_next;
            wmean_reg <= wmean_next;
            wcnt_reg  <= wcnt_next;
        end
    end

    assign burst_mean     = bmean_reg;
    assign burst_smallest = bmin_reg;
    assign burst_largest  = bmax_reg;
    assign burst_tally    = bcnt_reg;
    assign wait_mean      = wmean_reg;
    assign wait_tally     = wcnt_reg;

endmodule

`default_nettype wire

@@ rtl/core/burst_and_wait_running_stats.sv @@
// Channel | ports                                   | direction | word
// s_      | s_valid s_ready s_operation s_sample     | in        | one sample
// m_      | m_valid m_ready m_burst_* m_wait_*       | out       | all statistics
//
// An updating word steps through accept, multiply, add, 64 restoring divide
// steps, write back and publish; the output register loads in the publish step.
// An ignored word steps through accept, multiply and publish.
// Synchronous active-low reset clears the statistics and the output register, but sets the burst minimum to all ones.
// The publish step holds while the output register is still full; s_ready is
// high only in the idle step.
`default_nettype none

module burst_and_wait_running_stats (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_operation,
    input  wire logic signed [bwrs_pkg::SampleW-1:0]  s_sample,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [bwrs_pkg::SampleW-1:0]       m_burst_average,
    output logic        [bwrs_pkg::CountW-1:0]        m_burst_min,
    output logic        [bwrs_pkg::CountW-1:0]        m_burst_max,
    output logic        [bwrs_pkg::CountW-1:0]        m_burst_count,
    output logic signed [bwrs_pkg::SampleW-1:0]       m_wait_average,
    output logic        [bwrs_pkg::CountW-1:0]        m_wait_count
);

    localparam int SW = bwrs_pkg::SampleW;
    localparam int CW = bwrs_pkg::CountW;

    bwrs_pkg::ucode_t     ctrl;
    bwrs_pkg::dp_status_t status;
    logic                 out_free;
    logic                 load;

    logic signed [SW-1:0] burst_mean;
    logic        [CW-1:0] burst_smallest;
    logic        [CW-1:0] burst_largest;
    logic        [CW-1:0] burst_tally;
    logic signed [SW-1:0] wait_mean;
    logic        [CW-1:0] wait_tally;

    logic                 m_valid_reg, m_valid_next;
    logic signed [SW-1:0] bavg_reg;
    logic        [CW-1:0] bmin_reg;
    logic        [CW-1:0] bmax_reg;
    logic        [CW-1:0] bcnt_reg;
    logic signed [SW-1:0] wavg_reg;
    logic        [CW-1:0] wcnt_reg;

    bwrs_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .out_free (out_free),
        .status   (status),
        .ctrl     (ctrl)
    );

    bwrs_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .s_valid        (s_valid),
        .s_operation    (s_operation),
        .s_sample       (s_sample),
        .status         (status),
        .burst_mean     (burst_mean),
        .burst_smallest (burst_smallest),
        .burst_largest  (burst_largest),
        .burst_tally    (burst_tally),
        .wait_mean      (wait_mean),
        .wait_tally     (wait_tally)
    );

    // handshake
    assign s_ready  = ctrl.func == bwrs_pkg::FN_IDLE;
    assign out_free = !m_valid_reg || m_ready;
    assign load     = (ctrl.func == bwrs_pkg::FN_PUB) && out_free;

    always_comb begin
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            bavg_reg    <= '0;
            bmin_reg    <= bwrs_pkg::COUNT_MAX;
            bmax_reg    <= '0;
            bcnt_reg    <= '0;
            wavg_reg    <= '0;
            wcnt_reg    <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (load) begin
                bavg_reg <= burst_mean;
                bmin_reg <= burst_smallest;
                bmax_reg <= burst_largest;
                bcnt_reg <= burst_tally;
                wavg_reg <= wait_mean;
                wcnt_reg <= wait_tally;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_burst_average = bavg_reg;
    assign m_burst_min     = bmin_reg;
    assign m_burst_max     = bmax_reg;
    assign m_burst_count   = bcnt_reg;
    assign m_wait_average  = wavg_reg;
    assign m_wait_count    = wcnt_reg;

    // one word in flight at a time
    a_single_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a word is in flight");

    // published burst range is ordered once a burst is counted
    a_min_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_burst_count != '0) |-> (m_burst_min <= m_burst_max))
        else $error("burst min above burst max");

    // counts only grow
    a_count_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> ((m_burst_count >= $past(m_burst_count)) &&
                  (m_wait_count >= $past(m_wait_count))))
        else $error("published count decreased");

endmodule

`default_nettype wire
